// File: design/ppb_pkg.sv
// ppb_pkg: shared types, codes and helpers for the page-packed pixel buffer
// no dependencies; used by the interfaces' users, the controller and the datapath

package ppb_pkg;

  // byte positions reach (255/8)*255 + 255 = 8160, so 13 bits cover every case
  localparam int POS_W = 13;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_PIXEL = 2'd1,
    OP_FILL  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECIDE,
    ST_CLEAR,
    ST_FILL,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic fill_step;
    logic rd_issue;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic reject;
    logic clear_empty;
    logic rect_empty;
    logic lin_last;
    logic scan_last;
  } sts_t;

  // bits lo..hi set within one page byte
  function automatic logic [7:0] page_mask(input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[i] = (3'(i) >= lo) && (3'(i) <= hi);
    end
    return m;
  endfunction

endpackage

// File: design/ppb_if.sv
// ppb_if: request and result channel interfaces of the pixel buffer
// valid/ready handshake; no package dependency

interface ppb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] x;
  logic [7:0] y;
  logic [7:0] w;
  logic [7:0] h;
  logic       color;
  logic [7:0] index;

  modport source (output valid, output operation, output x, output y, output w, output h,
                  output color, output index, input ready);
  modport sink   (input valid, input operation, input x, input y, input w, input h,
                  input color, input index, output ready);
endinterface

interface ppb_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] read_data;

  modport source (output valid, output status, output read_data, input ready);
  modport sink   (input valid, input status, input read_data, output ready);
endinterface

// File: design/ppb_ctrl.sv
// ppb_ctrl: request sequencer of the pixel buffer
// depends on ppb_pkg (state_t, op_t, cmd_t, sts_t)

module ppb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ppb_pkg::cmd_t cmd,
  input  ppb_pkg::sts_t sts
);
  import ppb_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:   if (sts.lin_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        case (sts.op)
          OP_ALLOC: state_nxt = (sts.reject || sts.clear_empty) ? ST_DONE : ST_CLEAR;
          OP_PIXEL,
          OP_FILL:  state_nxt = sts.rect_empty ? ST_DONE : ST_FILL;
          OP_READ:  state_nxt = ST_READ;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_CLEAR:  if (sts.lin_last) state_nxt = ST_DONE;
      ST_FILL:   if (sts.scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_DONE;
      ST_READ:   state_nxt = ST_DONE;
      ST_DONE:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    in_ready      = (state_r == ST_IDLE);
    cmd.load      = in_valid && (state_r == ST_IDLE);
    cmd.clr_step  = (state_r == ST_INIT) || (state_r == ST_CLEAR);
    cmd.fill_step = (state_r == ST_FILL);
    cmd.rd_issue  = (state_r == ST_READ);
    cmd.res_load  = (state_r == ST_DONE) && slot_free;
    out_valid_nxt = cmd.res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

  a_fill_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) && sts.scan_last |=> (state_r == ST_DRAIN))
    else $error("fill scan end did not drain the last write");

  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && !out_ready |=> (state_r == ST_DONE))
    else $error("result overwritten while still pending");

  a_accept_decides: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r == ST_DECIDE))
    else $error("accepted request not decoded");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.clr_step, cmd.fill_step, cmd.rd_issue}))
    else $error("conflicting datapath commands");

endmodule

// File: design/ppb_dp.sv
// ppb_dp: pixel store, area registers, clipping and byte scan of the pixel buffer
// depends on ppb_pkg (op_t, cmd_t, sts_t, POS_W, page_mask)

module ppb_dp #(
  parameter int STORE_BYTES = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ppb_pkg::cmd_t cmd,
  output ppb_pkg::sts_t sts,
  input  ppb_pkg::op_t  in_op,
  input  logic [7:0]    in_x,
  input  logic [7:0]    in_y,
  input  logic [7:0]    in_w,
  input  logic [7:0]    in_h,
  input  logic          in_color,
  input  logic [7:0]    in_index,
  output logic          out_status,
  output logic [7:0]    out_read_data
);
  import ppb_pkg::*;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam logic [POS_W-1:0] STORE_LIM = POS_W'(STORE_BYTES);

  logic [7:0] mem [STORE_BYTES];

  // area and request registers
  logic [7:0]       area_w_r, area_h_r;
  op_t              op_r;
  logic             reject_r, color_r, idx_ok_r, rect_empty_r;
  logic [7:0]       idx_r;
  logic [7:0]       x0_r, x1_r, y0_r, y1_r, col_r;
  logic [4:0]       page_r;
  logic [POS_W-1:0] lin_r, lim_r;

  // write-back stage of the read-modify-write
  logic              wb_pend_r, wb_ok_r;
  logic [ADDR_W-1:0] wb_addr_r;
  logic [7:0]        wb_mask_r;
  logic [7:0]        rdata_r;
  logic [7:0]        out_data_r;
  logic              out_status_r;

  // request decode
  logic [5:0]       pages_h;
  logic [POS_W-1:0] need;
  logic             fits;
  logic [7:0]       fx, fy, fw, fh, rx, ry, rw, rh;
  logic             pix_in;

  always_comb begin
    pages_h = 6'((9'(in_h) + 9'd7) >> 3);
    need    = POS_W'(in_w) * POS_W'(pages_h);
    fits    = need <= STORE_LIM;

    fx = (in_x > area_w_r) ? area_w_r : in_x;
    fy = (in_y > area_h_r) ? area_h_r : in_y;
    fw = ((9'(fx) + 9'(in_w)) > 9'(area_w_r)) ? (area_w_r - fx) : in_w;
    fh = ((9'(fy) + 9'(in_h)) > 9'(area_h_r)) ? (area_h_r - fy) : in_h;

    pix_in = (in_x < area_w_r) && (in_y < area_h_r);
    if (in_op == OP_PIXEL) begin
      rx = in_x;
      ry = in_y;
      rw = {7'd0, pix_in};
      rh = {7'd0, pix_in};
    end else begin
      rx = fx;
      ry = fy;
      rw = fw;
      rh = fh;
    end
  end

  // scan position of the current byte
  logic [POS_W-1:0] scan_pos;
  logic [2:0]       mlo, mhi;
  logic [7:0]       scan_mask;
  logic             col_end, page_end;

  always_comb begin
    scan_pos  = POS_W'(page_r) * POS_W'(area_w_r) + POS_W'(col_r);
    mlo       = (page_r == y0_r[7:3]) ? y0_r[2:0] : 3'd0;
    mhi       = (page_r == y1_r[7:3]) ? y1_r[2:0] : 3'd7;
    scan_mask = page_mask(mlo, mhi);
    col_end   = (col_r == x1_r);
    page_end  = (page_r == y1_r[7:3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_w_r  <= '0;
      area_h_r  <= '0;
      lin_r     <= '0;
      lim_r     <= STORE_LIM;
      wb_pend_r <= 1'b0;
    end else begin
      wb_pend_r <= cmd.fill_step;
      if (cmd.clr_step) lin_r <= lin_r + 1'b1;
      if (cmd.load && (in_op == OP_ALLOC) && fits) begin
        area_w_r <= in_w;
        area_h_r <= in_h;
        lim_r    <= need;
        lin_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= in_op;
      reject_r     <= (in_op == OP_ALLOC) && !fits;
      color_r      <= in_color;
      idx_r        <= in_index;
      idx_ok_r     <= POS_W'(in_index) < STORE_LIM;
      rect_empty_r <= (rw == 8'd0) || (rh == 8'd0);
      x0_r         <= rx;
      x1_r         <= rx + rw - 8'd1;
      y0_r         <= ry;
      y1_r         <= ry + rh - 8'd1;
      col_r        <= rx;
      page_r       <= ry[7:3];
    end else if (cmd.fill_step) begin
      if (col_end) begin
        col_r  <= x0_r;
        page_r <= page_r + 5'd1;
      end else begin
        col_r <= col_r + 8'd1;
      end
    end
    if (cmd.fill_step) begin
      wb_addr_r <= ADDR_W'(scan_pos);
      wb_ok_r   <= scan_pos < STORE_LIM;
      wb_mask_r <= scan_mask;
    end
    if (cmd.res_load) begin
      out_status_r <= reject_r;
      out_data_r   <= ((op_r == OP_READ) && idx_ok_r) ? rdata_r : 8'd0;
    end
  end

  // store: one write and one registered read per cycle
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  always_comb begin
    mem_re    = cmd.fill_step || cmd.rd_issue;
    mem_raddr = cmd.rd_issue ? ADDR_W'(idx_r) : ADDR_W'(scan_pos);
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = ADDR_W'(lin_r);
      mem_wdata = 8'd0;
    end else begin
      mem_we    = wb_pend_r && wb_ok_r;
      mem_waddr = wb_addr_r;
      mem_wdata = color_r ? (rdata_r | wb_mask_r) : (rdata_r & ~wb_mask_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    sts             = '0;
    sts.op          = op_r;
    sts.reject      = reject_r;
    sts.clear_empty = (lim_r == '0);
    sts.rect_empty  = rect_empty_r;
    sts.lin_last    = (lin_r == lim_r - 1'b1);
    sts.scan_last   = col_end && page_end;
  end

  assign out_status    = out_status_r;
  assign out_read_data = out_data_r;

endmodule

// File: design/page_packed_pixel_buffer_unit.sv
// page_packed_pixel_buffer_unit: top level of the 1-bit page-packed pixel buffer
// depends on ppb_pkg, ppb_if (ppb_in_if, ppb_out_if), ppb_ctrl and ppb_dp
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    operation, x, y, w, h, color, index
//   out_ch   out  valid/ready    status, read_data
//
// one request at a time; after acceptance: DECIDE, then READ for a read, CLEAR for an
// allocation, FILL and DRAIN for pixel or fill (none if rejected or empty), then DONE;
// the next request is taken in the cycle the result shows at the earliest
// fill and clear run one store byte per cycle (read-modify-write pipelined on the store)
// after reset the whole store is cleared while in_ch.ready stays low
// a new request is taken while the previous result still waits on out_ch

module page_packed_pixel_buffer_unit #(
  parameter int STORE_BYTES = 256
) (
  input logic      clk,
  input logic      rst_n,
  ppb_in_if.sink   in_ch,
  ppb_out_if.source out_ch
);
  import ppb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ppb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ppb_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (op_t'(in_ch.operation)),
    .in_x          (in_ch.x),
    .in_y          (in_ch.y),
    .in_w          (in_ch.w),
    .in_h          (in_ch.h),
    .in_color      (in_ch.color),
    .in_index      (in_ch.index),
    .out_status    (out_ch.status),
    .out_read_data (out_ch.read_data)
  );

endmodule

// File: sim/tb_page_packed_pixel_buffer_unit.sv
// tb_page_packed_pixel_buffer_unit: self-checking bench for the page-packed pixel buffer
// depends on ppb_pkg, ppb_if and page_packed_pixel_buffer_unit; a shadow frame store
// predicts every reply, requests are directed first and then random under idle phases
`timescale 1ns / 100ps

module tb_page_packed_pixel_buffer_unit;
  import ppb_pkg::*;

  localparam int STORE_BYTES = 256;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS = 300;

  typedef struct {
    op_t        op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic       color;
    logic [7:0] index;
  } pixel_req_t;

  typedef struct {
    logic       status;
    logic [7:0] read_data;
  } pixel_reply_t;

  // shadow copy of the frame store; each request yields exactly one reply
  class frame_scoreboard;
    logic [7:0]   shadow_store[STORE_BYTES];
    int unsigned  area_w;
    int unsigned  area_h;
    pixel_reply_t awaited_replies[$];
    int           mismatch_count;

    function new();
      foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      area_w = 0;
      area_h = 0;
      mismatch_count = 0;
    endfunction

    function void plot(int unsigned px, int unsigned py, logic c);
      int unsigned pos;
      pos = (py >> 3) * area_w + px;
      if (pos < STORE_BYTES) shadow_store[pos][py & 7] = c;
    endfunction

    function void note_request(pixel_req_t r);
      pixel_reply_t rep;
      int unsigned  need, fx, fy, fw, fh;
      rep.status = 1'b0;
      rep.read_data = 8'h00;
      case (r.op)
        OP_ALLOC: begin
          need = int'(r.w) * ((int'(r.h) + 7) / 8);
          if (need > STORE_BYTES) begin
            rep.status = 1'b1;
          end else begin
            for (int i = 0; i < need; i++) shadow_store[i] = 8'h00;
            area_w = r.w;
            area_h = r.h;
          end
        end
        OP_PIXEL: begin
          if (r.x < area_w && r.y < area_h) plot(r.x, r.y, r.color);
        end
        OP_FILL: begin
          fx = r.x;
          fy = r.y;
          fw = r.w;
          fh = r.h;
          // clip the rectangle to the area border
          if (fx > area_w) fx = area_w;
          if (fy > area_h) fy = area_h;
          if (fx + fw > area_w) fw = area_w - fx;
          if (fy + fh > area_h) fh = area_h - fy;
          for (int unsigned row = fy; row < fy + fh; row++)
            for (int unsigned col = fx; col < fx + fw; col++)
              plot(col, row, r.color);
        end
        default: begin
          if (r.index < STORE_BYTES) rep.read_data = shadow_store[r.index];
        end
      endcase
      awaited_replies.push_back(rep);
    endfunction

    function void check_reply(logic status, logic [7:0] read_data);
      pixel_reply_t exp_rep;
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply with none awaited: status %0d read_data %02h",
                 $time, status, read_data);
        mismatch_count++;
        return;
      end
      exp_rep = awaited_replies.pop_front();
      if (status !== exp_rep.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, exp_rep.status, status);
        mismatch_count++;
      end
      if (read_data !== exp_rep.read_data) begin
        $display("%0t: read_data mismatch: expected %02h actual %02h",
                 $time, exp_rep.read_data, read_data);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ppb_in_if  in_ch();
  ppb_out_if out_ch();

  page_packed_pixel_buffer_unit #(.STORE_BYTES(STORE_BYTES)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  frame_scoreboard sb = new();

  int phase = 0;
  int sender_idle_pct[4] = '{0, 84, 0, 13};
  int recv_stall_pct[4]  = '{0, 0, 84, 13};
  logic hold_req = 1'b0;
  logic hold_on = 1'b0;
  int   cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // result side: check replies, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_reply(out_ch.status, out_ch.read_data);
    if (hold_on) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct[phase]);
    end
  end

  function automatic pixel_req_t make_req(op_t op, logic [7:0] x, logic [7:0] y,
                                          logic [7:0] w, logic [7:0] h, logic color,
                                          logic [7:0] index);
    pixel_req_t r;
    r.op = op;
    r.x = x;
    r.y = y;
    r.w = w;
    r.h = h;
    r.color = color;
    r.index = index;
    return r;
  endfunction

  // mostly well-formed requests aimed at the current area, some pure noise
  function automatic pixel_req_t random_req();
    pixel_req_t  r;
    int unsigned aw, ah, area_bytes, max_pages, max_h, roll;
    aw = sb.area_w;
    ah = sb.area_h;
    area_bytes = aw * ((ah + 7) / 8);
    r = make_req(op_t'(2'($urandom_range(3))), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 1'($urandom), 8'($urandom));
    roll = $urandom_range(99);
    if (roll < 10) return r;
    if (roll < 15) begin
      r.op = OP_ALLOC;
      if ($urandom_range(4) != 0) begin
        r.w = 8'($urandom_range(64, 1));
        max_pages = 256 / r.w;
        if (max_pages > 32) max_pages = 32;
        max_h = max_pages * 8;
        if (max_h > 255) max_h = 255;
        r.h = 8'($urandom_range(max_h, 1));
      end
    end else if (roll < 45) begin
      r.op = OP_PIXEL;
      if (aw != 0 && ah != 0 && $urandom_range(9) != 0) begin
        r.x = 8'($urandom_range(aw - 1, 0));
        r.y = 8'($urandom_range(ah - 1, 0));
      end
    end else if (roll < 68) begin
      r.op = OP_FILL;
      if ($urandom_range(9) != 0) begin
        r.x = 8'($urandom_range(aw, 0));
        r.y = 8'($urandom_range(ah, 0));
        r.w = 8'($urandom_range(16, 0));
        r.h = 8'($urandom_range(24, 0));
      end
    end else begin
      r.op = OP_READ;
      if (area_bytes != 0 && $urandom_range(4) != 0) begin
        r.index = 8'($urandom_range(area_bytes - 1, 0));
      end
    end
    return r;
  endfunction

  task automatic send_request(input pixel_req_t r);
    while ($urandom_range(99) < sender_idle_pct[phase]) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= r.op;
    in_ch.x         <= r.x;
    in_ch.y         <= r.y;
    in_ch.w         <= r.w;
    in_ch.h         <= r.h;
    in_ch.color     <= r.color;
    in_ch.index     <= r.index;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_READ;
    in_ch.x         <= 8'h00;
    in_ch.y         <= 8'h00;
    in_ch.w         <= 8'h00;
    in_ch.h         <= 8'h00;
    in_ch.color     <= 1'b0;
    in_ch.index     <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty area, size limits, clipping, edges of the store
    send_request(make_req(OP_READ,  0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_PIXEL, 0, 0, 0, 0, 1, 0));
    send_request(make_req(OP_FILL,  0, 0, 255, 255, 1, 0));
    send_request(make_req(OP_ALLOC, 0, 0, 255, 255, 0, 0));
    send_request(make_req(OP_ALLOC, 0, 0, 32, 64, 0, 0));
    send_request(make_req(OP_FILL,  0, 0, 255, 255, 1, 0));
    send_request(make_req(OP_READ,  0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_READ,  0, 0, 0, 0, 0, 255));
    send_request(make_req(OP_PIXEL, 31, 63, 0, 0, 0, 0));
    send_request(make_req(OP_PIXEL, 32, 0, 0, 0, 0, 0));
    send_request(make_req(OP_PIXEL, 0, 64, 0, 0, 0, 0));
    send_request(make_req(OP_READ,  0, 0, 0, 0, 0, 255));
    send_request(make_req(OP_FILL,  255, 255, 255, 255, 0, 0));
    send_request(make_req(OP_FILL,  3, 5, 2, 6, 0, 0));
    send_request(make_req(OP_READ,  0, 0, 0, 0, 0, 3));
    send_request(make_req(OP_ALLOC, 0, 0, 255, 8, 0, 0));
    send_request(make_req(OP_READ,  0, 0, 0, 0, 0, 255));
    send_request(make_req(OP_PIXEL, 254, 7, 0, 0, 1, 0));
    send_request(make_req(OP_READ,  0, 0, 0, 0, 0, 254));
    send_request(make_req(OP_ALLOC, 0, 0, 255, 9, 0, 0));
    send_request(make_req(OP_ALLOC, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_PIXEL, 255, 255, 0, 0, 1, 0));
    send_request(make_req(OP_READ,  0, 0, 0, 0, 0, 254));
    send_request(make_req(OP_ALLOC, 0, 0, 1, 255, 0, 0));
    send_request(make_req(OP_FILL,  0, 0, 1, 255, 1, 0));
    send_request(make_req(OP_READ,  0, 0, 0, 0, 0, 31));

    for (int p = 0; p < 4; p++) begin
      phase = p;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_request(random_req());
        // long receiver hold-off so the block backs up into its input
        if (p == 0 && i == 100) hold_req <= 1'b1;
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0 && sb.awaited_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
